// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the tag auto closer.
// Each macro expects a clock named clock in scope; ASSERT_CLK also expects a reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/ntac_pkg.sv -----
// Package of the tag auto closer: transaction types, codes and defaults.
// Used by ntac_stack and nested_tag_auto_closer; depends on nothing.
`timescale 1ns / 1ps

package ntac_pkg;

   localparam int DEFAULT_STACK_DEPTH = 32;
   localparam int DEFAULT_TAG_ID_BITS = 16;
   localparam int TAG_FIELD_BITS      = 16;

   typedef enum logic [1:0] {
      MODE_OPEN  = 2'd0,
      MODE_CLOSE = 2'd1,
      MODE_FLUSH = 2'd2
   } mode_type;

   localparam logic KIND_OPEN  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PASS
   } state_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic [TAG_FIELD_BITS-1:0] tag_id;
   } req_type;

   typedef struct packed {
      logic                      out_kind;
      logic [TAG_FIELD_BITS-1:0] out_tag;
      logic                      inserted;
      logic                      overflow;
      logic                      last;
   } rsp_type;

   // Commands from the sequencer to the stack memory.
   typedef struct packed {
      logic push;
      logic read;
   } stack_cmd_type;

endpackage

// ----- rtl/ntac_stack.sv -----
// Tag stack storage with a registered read port and the shared tag comparator.
// Depends on ntac_pkg for the command struct.
`timescale 1ns / 1ps

module ntac_stack #(
   parameter int DEPTH    = ntac_pkg::DEFAULT_STACK_DEPTH,
   parameter int TAG_BITS = ntac_pkg::DEFAULT_TAG_ID_BITS
) (
   input  logic                      clock,
   input  ntac_pkg::stack_cmd_type   cmd,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [TAG_BITS-1:0]       wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   input  logic [TAG_BITS-1:0]       key,
   output logic [TAG_BITS-1:0]       rd_data,
   output logic                      match
);

   logic [TAG_BITS-1:0] mem [DEPTH];
   logic [TAG_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // One comparator serves every step of the downward scan.
   assign rd_data = rd_data_ff;
   assign match   = (rd_data_ff == key);

endmodule

// ----- rtl/nested_tag_auto_closer.sv -----
// Top level of the tag auto closer: sequencer, stack count and result register.
// Depends on ntac_pkg, ntac_stack and assert_macros.svh.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall   ntac_pkg::req_type (mode, tag_id)
//   rsp_      out         rsp_valid / rsp_stall   ntac_pkg::rsp_type (kind, tag, flags)
//
// An open tag or a close on an empty stack answers from idle; a flush of an empty stack
// gives none. A close inserts one close per entry above its match, or per entry and then
// itself when none matches; a flush inserts one per entry. Without a result stall, the
// scan reads and compares one entry a cycle through the single registered read port.
// Reset is synchronous and empties the stack; stack contents are not cleared.
// A stall on the result side holds the sequencer in place without losing a step.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nested_tag_auto_closer #(
   parameter int STACK_DEPTH = ntac_pkg::DEFAULT_STACK_DEPTH,
   parameter int TAG_ID_BITS = ntac_pkg::DEFAULT_TAG_ID_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ntac_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ntac_pkg::rsp_type rsp_data
);

   // Only the low tag bits that fit both the field and the parameter are kept.
   localparam int TagW = (TAG_ID_BITS < ntac_pkg::TAG_FIELD_BITS) ?
                         TAG_ID_BITS : ntac_pkg::TAG_FIELD_BITS;
   localparam int CntW = $clog2(STACK_DEPTH + 1);
   localparam int IdxW = $clog2(STACK_DEPTH);

   ntac_pkg::state_type     state_ff, state_in;
   logic [CntW-1:0]         count_ff, count_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   logic [TagW-1:0]         tag_ff, tag_in;
   logic                    flush_ff, flush_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ntac_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    rsp_load;

   ntac_pkg::stack_cmd_type stack_cmd;
   logic [IdxW-1:0]         rd_addr;
   logic [TagW-1:0]         rd_data;
   logic                    match;

   logic                    slot_free;
   logic                    req_fire;
   logic                    stack_full;
   logic [CntW-1:0]         count_dec;
   logic [TagW-1:0]         req_tag;

   logic                    scan_active;
   logic                    open_fire;
   logic                    open_done;

   // The result register can take a new transaction when it is empty or draining.
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ntac_pkg::ST_IDLE) || !slot_free;
   assign req_fire   = req_valid && !req_stall;
   assign stack_full = (count_ff >= CntW'(STACK_DEPTH));
   assign count_dec  = count_ff - CntW'(1);
   assign req_tag    = req_data.tag_id[TagW-1:0];

   ntac_stack #(
      .DEPTH    (STACK_DEPTH),
      .TAG_BITS (TagW)
   ) u_stack (
      .clock   (clock),
      .cmd     (stack_cmd),
      .wr_addr (count_ff[IdxW-1:0]),
      .wr_data (req_tag),
      .rd_addr (rd_addr),
      .key     (tag_ff),
      .rd_data (rd_data),
      .match   (match)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ntac_pkg::ST_IDLE: begin
            if (req_fire && count_ff != '0 &&
                (req_data.mode == ntac_pkg::MODE_CLOSE ||
                 req_data.mode == ntac_pkg::MODE_FLUSH)) begin
               state_in = ntac_pkg::ST_SCAN;
            end
         end
         ntac_pkg::ST_SCAN: begin
            if (slot_free) begin
               if (!flush_ff && match) begin
                  state_in = ntac_pkg::ST_IDLE;
               end else if (idx_ff == '0) begin
                  state_in = flush_ff ? ntac_pkg::ST_IDLE : ntac_pkg::ST_PASS;
               end
            end
         end
         ntac_pkg::ST_PASS: begin
            if (slot_free) begin
               state_in = ntac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ntac_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control and result formation.
   always_comb begin
      stack_cmd = '0;
      rd_addr   = idx_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      tag_in    = tag_ff;
      flush_in  = flush_ff;
      rsp_load  = 1'b0;
      rsp_in    = rsp_ff;
      case (state_ff)
         ntac_pkg::ST_IDLE: begin
            if (req_fire) begin
               tag_in   = req_tag;
               flush_in = (req_data.mode == ntac_pkg::MODE_FLUSH);
               case (req_data.mode)
                  ntac_pkg::MODE_OPEN: begin
                     if (!stack_full) begin
                        stack_cmd.push = 1'b1;
                        count_in       = count_ff + CntW'(1);
                     end
                     rsp_load        = 1'b1;
                     rsp_in.out_kind = ntac_pkg::KIND_OPEN;
                     rsp_in.out_tag  = ntac_pkg::TAG_FIELD_BITS'(req_tag);
                     rsp_in.inserted = 1'b0;
                     rsp_in.overflow = stack_full;
                     rsp_in.last     = 1'b1;
                  end
                  ntac_pkg::MODE_CLOSE: begin
                     if (count_ff == '0) begin
                        // Nothing open: the close goes straight through.
                        rsp_load        = 1'b1;
                        rsp_in.out_kind = ntac_pkg::KIND_CLOSE;
                        rsp_in.out_tag  = ntac_pkg::TAG_FIELD_BITS'(req_tag);
                        rsp_in.inserted = 1'b0;
                        rsp_in.overflow = 1'b0;
                        rsp_in.last     = 1'b1;
                     end else begin
                        stack_cmd.read = 1'b1;
                        rd_addr        = count_dec[IdxW-1:0];
                        idx_in         = count_dec[IdxW-1:0];
                     end
                  end
                  ntac_pkg::MODE_FLUSH: begin
                     if (count_ff != '0) begin
                        stack_cmd.read = 1'b1;
                        rd_addr        = count_dec[IdxW-1:0];
                        idx_in         = count_dec[IdxW-1:0];
                     end
                  end
                  default: begin
                     // The unused mode code is dropped without any result.
                  end
               endcase
            end
         end
         ntac_pkg::ST_SCAN: begin
            if (slot_free) begin
               rsp_load        = 1'b1;
               rsp_in.out_kind = ntac_pkg::KIND_CLOSE;
               rsp_in.overflow = 1'b0;
               if (!flush_ff && match) begin
                  // The matching entry pops with the original close.
                  rsp_in.out_tag  = ntac_pkg::TAG_FIELD_BITS'(tag_ff);
                  rsp_in.inserted = 1'b0;
                  rsp_in.last     = 1'b1;
                  count_in        = CntW'(idx_ff);
               end else begin
                  rsp_in.out_tag  = ntac_pkg::TAG_FIELD_BITS'(rd_data);
                  rsp_in.inserted = 1'b1;
                  rsp_in.last     = flush_ff && (idx_ff == '0);
                  if (idx_ff == '0) begin
                     count_in = '0;
                  end else begin
                     stack_cmd.read = 1'b1;
                     rd_addr        = idx_ff - IdxW'(1);
                     idx_in         = idx_ff - IdxW'(1);
                  end
               end
            end
         end
         ntac_pkg::ST_PASS: begin
            if (slot_free) begin
               // The stack emptied without a match; the close follows.
               rsp_load        = 1'b1;
               rsp_in.out_kind = ntac_pkg::KIND_CLOSE;
               rsp_in.out_tag  = ntac_pkg::TAG_FIELD_BITS'(tag_ff);
               rsp_in.inserted = 1'b0;
               rsp_in.overflow = 1'b0;
               rsp_in.last     = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntac_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      tag_ff   <= tag_in;
      flush_ff <= flush_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Terms of the checks below.
   assign scan_active = (state_ff == ntac_pkg::ST_SCAN);
   assign open_fire   = req_fire && (req_data.mode == ntac_pkg::MODE_OPEN);
   assign open_done   = rsp_valid_ff && rsp_ff.last && (state_ff == ntac_pkg::ST_IDLE);

   // A scan only runs over a nonempty stack and below its top.
   `ASSERT_CLK(a_scan_nonempty, scan_active |-> (count_ff != '0), "scan on empty stack")
   `ASSERT_CLK(a_scan_index, scan_active |-> (CntW'(idx_ff) < count_ff), "scan index above top")
   // A push never lands on a full stack.
   `ASSERT_CLK(a_push_room, stack_cmd.push |-> !stack_full, "push on full stack")
   // An open tag gives exactly one result, marked as the last one.
   `ASSERT_CLK(a_open_single, open_fire |=> open_done, "open tag did not give one final result")

endmodule
